>>> design/tfd_pkg.sv
`default_nettype none
package tfd_pkg;

	localparam int unsigned HEADER_BYTES = 36;
	localparam int unsigned RECORD_BYTES = 44;

	localparam logic [4:0] CODE_TYPE     = 5'd0;
	localparam logic [4:0] CODE_SEQ      = 5'd1;
	localparam logic [4:0] CODE_FLAGS    = 5'd2;
	localparam logic [4:0] CODE_COUNT    = 5'd3;
	localparam logic [4:0] CODE_CAPTURE  = 5'd4;
	localparam logic [4:0] CODE_DEVICE   = 5'd5;
	localparam logic [4:0] CODE_C_ID     = 5'd6;
	localparam logic [4:0] CODE_C_STATE  = 5'd7;
	localparam logic [4:0] CODE_C_FLAGS  = 5'd8;
	localparam logic [4:0] CODE_C_FLOAT0 = 5'd9;
	localparam logic [4:0] CODE_VERDICT  = 5'd18;

	localparam logic [2:0] REG_MAGIC   = 3'd0;
	localparam logic [2:0] REG_VERSION = 3'd1;
	localparam logic [2:0] REG_HELLO   = 3'd2;
	localparam logic [2:0] REG_FRAME   = 3'd3;
	localparam logic [2:0] REG_RESET   = 3'd4;
	localparam logic [2:0] REG_BUTTONS = 3'd5;

	localparam logic [5:0] HDR_MAGIC_END   = 6'd3;
	localparam logic [5:0] HDR_VERSION_END = 6'd5;
	localparam logic [5:0] HDR_TYPE_END    = 6'd7;
	localparam logic [5:0] HDR_PAYLOAD_END = 6'd11;
	localparam logic [5:0] HDR_SEQ_END     = 6'd15;
	localparam logic [5:0] HDR_COUNT_END   = 6'd17;
	localparam logic [5:0] HDR_FLAGS_END   = 6'd19;
	localparam logic [5:0] HDR_CAPTURE_END = 6'd27;
	localparam logic [5:0] HDR_DEVICE_END  = 6'd35;

	localparam logic [5:0] REC_ID_END     = 6'd3;
	localparam logic [5:0] REC_STATE      = 6'd4;
	localparam logic [5:0] REC_FLAGS      = 6'd5;
	localparam logic [5:0] REC_FLOAT0_END = 6'd11;
	localparam logic [5:0] REC_LAST       = 6'd43;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;

	typedef struct packed {
		logic [4:0]  code;
		logic [3:0]  index;
		logic [63:0] value;
		logic        valid;
		logic        fin;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
		logic       narrow;
	} rec_field_t;

	function automatic rec_field_t rec_field(input logic [5:0] o);
		rec_field_t f;
		logic [5:0] rel;
		f = '0;
		rel = o - REC_FLOAT0_END;
		if (o == REC_ID_END) begin
			f.hit = 1'b1;
			f.code = CODE_C_ID;
		end else if (o == REC_STATE) begin
			f.hit = 1'b1;
			f.code = CODE_C_STATE;
			f.narrow = 1'b1;
		end else if (o == REC_FLAGS) begin
			f.hit = 1'b1;
			f.code = CODE_C_FLAGS;
			f.narrow = 1'b1;
		end else if (o >= REC_FLOAT0_END && rel[1:0] == 2'b00) begin
			f.hit = 1'b1;
			f.code = CODE_C_FLOAT0 + {1'b0, rel[5:2]};
		end
		return f;
	endfunction

endpackage
`default_nettype wire

>>> design/touch_frame_decoder.sv
// Touch contact message decoder.
// Input: one message byte per transfer on s_tdata[7:0], s_tlast on the final
// byte. Output: one decoded field per transfer; m_tdata holds field code,
// contact index and 64-bit value, m_tuser the verdict, m_tlast marks the
// verdict transfer that closes a message.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register (magic, version, hello, frame, reset code, button mask), always
// ready; write only while the block is idle.
// Throughput: one byte per cycle while s_tready is high. A byte yields zero, one or two results;
// results leave through a 4-entry queue at one per cycle while m_tready is high.
// Each result is registered in the queue and reaches m_tvalid behind any results queued before it.
// s_tready drops when the queue has fewer than two free slots, so a stalled
// receiver backs up into the byte stream without losing results.
// Reset: clears parse state and queue, loads register defaults.
`default_nettype none
module touch_frame_decoder #(
	parameter int MAX_CONTACTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,  // [4:0] field_code, [8:5] contact_index, [72:9] field_value
	output logic             m_tuser,  // [0] message_valid
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import tfd_pkg::*;

	push_t   push;
	result_t head;
	logic    room2;

	assign s_tready  = room2;
	assign cfg_ready = 1'b1;

	tfd_parser #(
		.MAX_CONTACTS(MAX_CONTACTS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(s_tvalid && s_tready),
		.byte_data (s_tdata),
		.byte_last (s_tlast),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_sel   (cfg_index),
		.cfg_wdata (cfg_data),
		.push      (push)
	);

	tfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.head      (head),
		.head_valid(m_tvalid),
		.pop       (m_tready),
		.room2     (room2)
	);

	assign m_tdata = {7'b0, head.value, head.index, head.code};
	assign m_tuser = head.valid;
	assign m_tlast = head.fin;

endmodule
`default_nettype wire

>>> design/tfd_parser.sv
`default_nettype none
module tfd_parser #(
	parameter int MAX_CONTACTS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            byte_valid,
	input  wire logic [7:0]      byte_data,
	input  wire logic            byte_last,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_sel,
	input  wire logic [31:0]     cfg_wdata,
	output tfd_pkg::push_t       push
);
	import tfd_pkg::*;

	localparam logic [15:0] MaxCount = 16'(MAX_CONTACTS);

	logic [31:0] magic_q;
	logic [15:0] version_q, hello_q, frame_q, reset_code_q, buttons_q;

	logic [15:0] pos_q, pos_d;
	logic [63:0] shift_q, shift_d;
	logic [31:0] payload_q, payload_d;
	logic [15:0] count_q, count_d;
	logic [15:0] type_q, type_d;
	logic        err_q, err_d;
	logic [4:0]  cc_q, cc_d;
	logic [5:0]  off_q, off_d;

	logic [15:0] lo16;
	logic [31:0] lo32;
	logic        fld_hit;
	result_t     fld, verdict;
	rec_field_t  rf;
	logic [32:0] want_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q      <= '0;
			version_q    <= 16'd1;
			hello_q      <= 16'd1;
			frame_q      <= 16'd2;
			reset_code_q <= 16'd3;
			buttons_q    <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				REG_MAGIC:   magic_q      <= cfg_wdata;
				REG_VERSION: version_q    <= cfg_wdata[15:0];
				REG_HELLO:   hello_q      <= cfg_wdata[15:0];
				REG_FRAME:   frame_q      <= cfg_wdata[15:0];
				REG_RESET:   reset_code_q <= cfg_wdata[15:0];
				REG_BUTTONS: buttons_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		shift_d   = {shift_q[55:0], byte_data};
		lo16      = shift_d[15:0];
		lo32      = shift_d[31:0];
		pos_d     = pos_q;
		payload_d = payload_q;
		count_d   = count_q;
		type_d    = type_q;
		err_d     = err_q;
		cc_d      = cc_q;
		off_d     = off_q;
		fld_hit   = 1'b0;
		fld       = '0;
		rf        = rec_field(off_q);

		if (pos_q < 16'(HEADER_BYTES)) begin
			case (pos_q[5:0])
				HDR_MAGIC_END: if (lo32 != magic_q) err_d = 1'b1;
				HDR_VERSION_END: if (lo16 != version_q) err_d = 1'b1;
				HDR_TYPE_END: begin
					type_d = lo16;
					if (lo16 < hello_q || lo16 > reset_code_q) err_d = 1'b1;
					fld_hit = 1'b1;
					fld.code = CODE_TYPE;
					fld.value = {48'b0, lo16};
				end
				HDR_PAYLOAD_END: payload_d = lo32;
				HDR_SEQ_END: begin
					fld_hit = 1'b1;
					fld.code = CODE_SEQ;
					fld.value = {32'b0, lo32};
				end
				HDR_COUNT_END: begin
					count_d = lo16;
					if (lo16 > MaxCount) err_d = 1'b1;
					if (payload_q != {16'b0, lo16} * 32'(RECORD_BYTES)) err_d = 1'b1;
					fld_hit = 1'b1;
					fld.code = CODE_COUNT;
					fld.value = {48'b0, lo16};
				end
				HDR_FLAGS_END: begin
					if ((lo16 & ~buttons_q) != 16'd0) err_d = 1'b1;
					if (type_q != frame_q && (count_q != 16'd0 || lo16 != 16'd0))
						err_d = 1'b1;
					fld_hit = 1'b1;
					fld.code = CODE_FLAGS;
					fld.value = {48'b0, lo16};
				end
				HDR_CAPTURE_END: begin
					fld_hit = 1'b1;
					fld.code = CODE_CAPTURE;
					fld.value = shift_d;
				end
				HDR_DEVICE_END: begin
					fld_hit = 1'b1;
					fld.code = CODE_DEVICE;
					fld.value = shift_d;
				end
				default: ;
			endcase
		end else begin
			if ({11'b0, cc_q} < count_q && rf.hit) begin
				fld_hit = 1'b1;
				fld.code = rf.code;
				fld.index = cc_q[3:0];
				fld.value = rf.narrow ? {56'b0, shift_d[7:0]} : {32'b0, lo32};
			end
			if (off_q == REC_LAST) begin
				off_d = '0;
				if (cc_q != 5'd31) cc_d = cc_q + 5'd1;
			end else begin
				off_d = off_q + 6'd1;
			end
		end

		want_len = 33'(HEADER_BYTES) + {1'b0, payload_d};
		verdict = '0;
		verdict.code = CODE_VERDICT;
		verdict.fin = 1'b1;
		verdict.valid = !err_d && ({17'b0, pos_q} + 33'd1 == want_len);

		push = '0;
		if (byte_valid) begin
			if (fld_hit) begin
				push.r0 = fld;
				push.r1 = verdict;
				push.count = byte_last ? 2'd2 : 2'd1;
			end else if (byte_last) begin
				push.r0 = verdict;
				push.count = 2'd1;
			end
		end

		if (byte_last) begin
			shift_d   = '0;
			pos_d     = '0;
			payload_d = '0;
			count_d   = '0;
			type_d    = '0;
			err_d     = 1'b0;
			cc_d      = '0;
			off_d     = '0;
		end else if (pos_q == 16'hFFFF) begin
			err_d = 1'b1;
		end else begin
			pos_d = pos_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			shift_q   <= '0;
			payload_q <= '0;
			count_q   <= '0;
			type_q    <= '0;
			err_q     <= 1'b0;
			cc_q      <= '0;
			off_q     <= '0;
		end else if (byte_valid) begin
			pos_q     <= pos_d;
			shift_q   <= shift_d;
			payload_q <= payload_d;
			count_q   <= count_d;
			type_q    <= type_d;
			err_q     <= err_d;
			cc_q      <= cc_d;
			off_q     <= off_d;
		end
	end

endmodule
`default_nettype wire

>>> design/tfd_queue.sv
`default_nettype none
module tfd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tfd_pkg::push_t  push,
	output tfd_pkg::result_t     head,
	output logic                 head_valid,
	input  wire logic            pop,
	output logic                 room2
);
	import tfd_pkg::*;

	result_t mem [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   fill_q;
	logic           do_pop;

	assign head_valid = fill_q != '0;
	assign head       = mem[rd_q];
	assign room2      = fill_q <= (QAW+1)'(QDEPTH - 2);
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem[wr_q] <= push.r0;
		if (push.count == 2'd2) mem[wr_q + QAW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + QAW'(push.count);
			rd_q   <= rd_q + QAW'(do_pop);
			fill_q <= fill_q + (QAW+1)'(push.count) - (QAW+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import tfd_pkg::*;

	localparam int MAX_CONTACTS = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_BYTES = 80;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       calm;
	} wire_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	touch_frame_decoder #(.MAX_CONTACTS(MAX_CONTACTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register copies
	logic [31:0] reg_magic = '0;
	logic [15:0] reg_version = 16'd1;
	logic [15:0] reg_hello = 16'd1;
	logic [15:0] reg_frame = 16'd2;
	logic [15:0] reg_reset = 16'd3;
	logic [15:0] reg_buttons = 16'd1;

	// parser state
	logic [15:0] msg_pos = '0;
	logic [63:0] shift_acc = '0;
	logic [31:0] hdr_payload = '0;
	logic [15:0] hdr_count = '0;
	logic [15:0] hdr_type = '0;
	logic        msg_bad = 1'b0;
	logic [4:0]  rec_num = '0;
	logic [5:0]  rec_off = '0;

	wire_byte_t tx_bytes[$];
	result_t    fields_due[$];
	logic [7:0] msg[$];

	int bytes_queued = 0;
	int bytes_taken = 0;
	int mismatches = 0;
	int gap_left = 0;
	int rx_wait = 0;
	int rx_idle_max = 9;
	logic hold_go = 1'b0;
	logic rx_hold = 1'b0;
	wire_byte_t nxt;
	result_t want;

	function automatic void add_due(input logic [4:0] code, input logic [3:0] idx,
			input logic [63:0] value, input logic ok, input logic fin);
		result_t r;
		r.code = code;
		r.index = idx;
		r.value = value;
		r.valid = ok;
		r.fin = fin;
		fields_due.push_back(r);
	endfunction

	function automatic void clear_parser();
		msg_pos = '0;
		shift_acc = '0;
		hdr_payload = '0;
		hdr_count = '0;
		hdr_type = '0;
		msg_bad = 1'b0;
		rec_num = '0;
		rec_off = '0;
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic last);
		logic [15:0] p;
		logic [15:0] lo16;
		logic [31:0] lo32;
		logic [5:0]  rel;
		logic        ok;
		p = msg_pos;
		shift_acc = {shift_acc[55:0], b};
		lo16 = shift_acc[15:0];
		lo32 = shift_acc[31:0];
		if (p < HEADER_BYTES) begin
			case (p[5:0])
			HDR_MAGIC_END: begin
				if (lo32 != reg_magic) msg_bad = 1'b1;
			end
			HDR_VERSION_END: begin
				if (lo16 != reg_version) msg_bad = 1'b1;
			end
			HDR_TYPE_END: begin
				hdr_type = lo16;
				if (lo16 < reg_hello || lo16 > reg_reset) msg_bad = 1'b1;
				add_due(CODE_TYPE, '0, 64'(lo16), 1'b0, 1'b0);
			end
			HDR_PAYLOAD_END: begin
				hdr_payload = lo32;
			end
			HDR_SEQ_END: begin
				add_due(CODE_SEQ, '0, 64'(lo32), 1'b0, 1'b0);
			end
			HDR_COUNT_END: begin
				hdr_count = lo16;
				if (32'(lo16) > MAX_CONTACTS) msg_bad = 1'b1;
				if (hdr_payload != 32'(lo16) * RECORD_BYTES) msg_bad = 1'b1;
				add_due(CODE_COUNT, '0, 64'(lo16), 1'b0, 1'b0);
			end
			HDR_FLAGS_END: begin
				if ((lo16 & ~reg_buttons) != '0) msg_bad = 1'b1;
				if (hdr_type != reg_frame && (hdr_count != '0 || lo16 != '0))
					msg_bad = 1'b1;
				add_due(CODE_FLAGS, '0, 64'(lo16), 1'b0, 1'b0);
			end
			HDR_CAPTURE_END: add_due(CODE_CAPTURE, '0, shift_acc, 1'b0, 1'b0);
			HDR_DEVICE_END: add_due(CODE_DEVICE, '0, shift_acc, 1'b0, 1'b0);
			default: ;
			endcase
		end else begin
			// records past the announced count are swallowed
			if (16'(rec_num) < hdr_count) begin
				rel = rec_off - REC_FLOAT0_END;
				if (rec_off == REC_ID_END)
					add_due(CODE_C_ID, rec_num[3:0], 64'(lo32), 1'b0, 1'b0);
				else if (rec_off == REC_STATE)
					add_due(CODE_C_STATE, rec_num[3:0], 64'(b), 1'b0, 1'b0);
				else if (rec_off == REC_FLAGS)
					add_due(CODE_C_FLAGS, rec_num[3:0], 64'(b), 1'b0, 1'b0);
				else if (rec_off >= REC_FLOAT0_END && rel[1:0] == 2'b00)
					add_due(CODE_C_FLOAT0 + 5'(rel[5:2]), rec_num[3:0], 64'(lo32),
						1'b0, 1'b0);
			end
			if (rec_off == REC_LAST) begin
				rec_off = '0;
				if (rec_num != 5'd31) rec_num = rec_num + 5'd1;
			end else begin
				rec_off = rec_off + 6'd1;
			end
		end
		if (last) begin
			ok = !msg_bad &&
				(64'(p) + 64'd1 == 64'(HEADER_BYTES) + 64'(hdr_payload));
			add_due(CODE_VERDICT, '0, '0, ok, 1'b1);
			clear_parser();
		end else if (p == 16'hFFFF) begin
			msg_bad = 1'b1;
		end else begin
			msg_pos = p + 16'd1;
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		mismatches++;
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, exp_val);
	endtask

	function automatic void put_be(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			msg.push_back(v[8*i +: 8]);
	endfunction

	function automatic void build_msg(input logic [15:0] mtype, input int ncontacts,
			input logic [15:0] flags);
		msg.delete();
		put_be(64'(reg_magic), 4);
		put_be(64'(reg_version), 2);
		put_be(64'(mtype), 2);
		put_be(64'(ncontacts * RECORD_BYTES), 4);
		put_be(64'($urandom), 4);
		put_be(64'(ncontacts), 2);
		put_be(64'(flags), 2);
		repeat (4) put_be(64'($urandom), 4);
		repeat (ncontacts * RECORD_BYTES) msg.push_back(8'($urandom));
	endfunction

	function automatic int queue_msg(input logic calm);
		wire_byte_t wb;
		for (int i = 0; i < msg.size(); i++) begin
			wb.data = msg[i];
			wb.last = (i == msg.size() - 1);
			wb.calm = calm;
			tx_bytes.push_back(wb);
		end
		bytes_queued += msg.size();
		return msg.size();
	endfunction

	// mostly well formed messages, the rest broken or noise
	function automatic int queue_random_msg();
		int cnt;
		int cut;
		logic [15:0] mt;
		logic [15:0] fl;
		cnt = ($urandom_range(0, 11) == 0) ? MAX_CONTACTS : $urandom_range(0, 3);
		case ($urandom_range(0, 3))
		0: mt = reg_hello;
		1: mt = reg_reset;
		default: mt = reg_frame;
		endcase
		if (mt == reg_frame) begin
			fl = 16'($urandom) & reg_buttons;
		end else begin
			fl = '0;
			cnt = 0;
		end
		build_msg(mt, cnt, fl);
		if ($urandom_range(0, 9) >= 7) begin
			case ($urandom_range(0, 9))
			0: msg[1] ^= 8'h01 << $urandom_range(0, 7);
			1: msg[5] ^= 8'h01 << $urandom_range(0, 7);
			2: msg[7] ^= 8'h01 << $urandom_range(0, 7);
			3: msg[10] ^= 8'h01 << $urandom_range(0, 7);
			4: build_msg(reg_frame, MAX_CONTACTS + $urandom_range(1, 3), fl);
			5: msg[19] ^= 8'h01 << $urandom_range(0, 7);
			6: begin
				cut = $urandom_range(1, msg.size() - 1);
				while (msg.size() > cut) void'(msg.pop_back());
			end
			7: repeat ($urandom_range(1, 60)) msg.push_back(8'($urandom));
			8: begin
				msg.delete();
				repeat ($urandom_range(1, 80)) msg.push_back(8'($urandom));
			end
			default: build_msg(reg_hello, $urandom_range(1, 2), 16'($urandom));
			endcase
		end
		return queue_msg($urandom_range(0, 2) == 0);
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_MAGIC: reg_magic = val;
		REG_VERSION: reg_version = val[15:0];
		REG_HELLO: reg_hello = val[15:0];
		REG_FRAME: reg_frame = val[15:0];
		REG_RESET: reg_reset = val[15:0];
		REG_BUTTONS: reg_buttons = val[15:0];
		default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] magic, input logic [15:0] version,
			input logic [15:0] hello, input logic [15:0] frame, input logic [15:0] rst_code,
			input logic [15:0] buttons);
		write_reg(REG_MAGIC, magic);
		write_reg(REG_VERSION, 32'(version));
		write_reg(REG_HELLO, 32'(hello));
		write_reg(REG_FRAME, 32'(frame));
		write_reg(REG_RESET, 32'(rst_code));
		write_reg(REG_BUTTONS, 32'(buttons));
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (bytes_taken != bytes_queued || fields_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(64'd10_000_000);
		$display("tb: failure");
		$finish;
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// byte sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (tx_bytes.size() != 0) begin
					nxt = tx_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data;
					s_tlast <= nxt.last;
					gap_left = nxt.calm ? 0 : $urandom_range(0, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (fields_due.size() == 0) begin
					report_mismatch("result with nothing due", 64'(m_tdata[4:0]), '0);
				end else begin
					want = fields_due.pop_front();
					if (m_tdata[4:0] != want.code)
						report_mismatch("field_code", 64'(m_tdata[4:0]), 64'(want.code));
					if (m_tdata[8:5] != want.index)
						report_mismatch("contact_index", 64'(m_tdata[8:5]), 64'(want.index));
					if (m_tdata[72:9] != want.value)
						report_mismatch("field_value", m_tdata[72:9], want.value);
					if (m_tuser != want.valid)
						report_mismatch("message_valid", 64'(m_tuser), 64'(want.valid));
					if (m_tlast != want.fin)
						report_mismatch("final_result", 64'(m_tlast), 64'(want.fin));
				end
				rx_wait = $urandom_range(0, rx_idle_max);
			end
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int sent;
		logic [15:0] h;
		logic [15:0] f;
		logic [15:0] r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// short messages, a double result on the type byte, byte extremes
		msg = '{8'h00};
		void'(queue_msg(1'b0));
		msg = '{8'hFF};
		void'(queue_msg(1'b0));
		build_msg(reg_frame, 0, '0);
		while (msg.size() > 8) void'(msg.pop_back());
		void'(queue_msg(1'b1));
		msg.delete();
		repeat (12) msg.push_back(8'($urandom));
		void'(queue_msg(1'b0));
		wait_idle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: set_regs(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
			1: set_regs(32'h0000_0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
			2: set_regs($urandom, 16'd1, 16'd1, 16'd2, 16'd3, 16'd1);
			3: begin
				h = 16'($urandom_range(0, 100));
				f = h + 16'($urandom_range(0, 100));
				r = f + 16'($urandom_range(0, 100));
				set_regs($urandom, 16'($urandom), h, f, r, 16'($urandom));
			end
			default: set_regs($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom));
			endcase
			rx_idle_max = (ph == 1 || ph == 4) ? 0 : 9;
			if (ph == 0) hold_go = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) sent += queue_random_msg();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (fields_due.size() != 0)
			report_mismatch("results never arrived", 64'(fields_due.size()), '0);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
design/tfd_pkg.sv
design/tfd_parser.sv
design/tfd_queue.sv
design/touch_frame_decoder.sv
dv/tb_top.sv
